### hw/rtl/ucodec_pkg.sv
`timescale 1ns / 1ps

package ucodec_pkg;

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int PH_W   = 2;
    localparam int CNT_W  = 2;

    localparam logic [PH_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PH_W-1:0] PH_HIGH = 2'd1;
    localparam logic [PH_W-1:0] PH_LOW  = 2'd2;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic              last;
        logic              err;
        logic [PH_W-1:0]   phase;
        logic [NIB_W-1:0]  nib;
    } t_xres;

    function automatic logic is_upper(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [BYTE_W-1:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] v);
        logic [BYTE_W-1:0] w;
        w = {4'd0, v};
        return (v > 4'd9) ? w + 8'd55 : w + 8'd48;
    endfunction

    // lenient digit: 0-9, letters 10-35, others 0
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        if (is_upper(c)) begin
            v = c - 8'h41 + 8'd10;
        end else if (is_lower(c)) begin
            v = c - 8'h61 + 8'd10;
        end else if (is_digit(c)) begin
            v = c - 8'h30;
        end else begin
            v = 8'd0;
        end
        return v;
    endfunction

    function automatic logic is_unreserved(input logic [BYTE_W-1:0] c);
        return is_upper(c) || is_lower(c) || is_digit(c) || (c == CH_DASH)
            || (c == CH_USCORE) || (c == CH_DOT) || (c == CH_TILDE);
    endfunction

endpackage

### hw/rtl/ucodec_xlate.sv
`timescale 1ns / 1ps

module ucodec_xlate (
    input  logic [ucodec_pkg::BYTE_W-1:0] i_byte,
    input  logic                          i_last,
    input  logic                          i_dir,
    input  logic [ucodec_pkg::PH_W-1:0]   i_phase,
    input  logic [ucodec_pkg::NIB_W-1:0]  i_nib,
    output ucodec_pkg::t_xres             o_res
);
    import ucodec_pkg::*;

    logic [BYTE_W-1:0] dval;

    assign dval = digit_value(i_byte);

    always_comb begin
        o_res       = '0;
        o_res.last  = i_last;
        o_res.phase = PH_IDLE;
        o_res.nib   = '0;
        if (i_dir == DIR_ENCODE) begin
            if (is_unreserved(i_byte)) begin
                o_res.cnt = 2'd1;
                o_res.b0  = i_byte;
            end else if (i_byte == CH_SPACE) begin
                o_res.cnt = 2'd1;
                o_res.b0  = CH_PLUS;
            end else begin
                o_res.cnt = 2'd3;
                o_res.b0  = CH_PCT;
                o_res.b1  = hex_char(i_byte[7:4]);
                o_res.b2  = hex_char(i_byte[3:0]);
            end
        end else begin
            priority if (i_phase == PH_HIGH) begin
                if (i_last) begin
                    o_res.cnt = 2'd1;
                    o_res.err = 1'b1;
                end else begin
                    o_res.phase = PH_LOW;
                    o_res.nib   = dval[NIB_W-1:0];
                end
            end else if (i_phase == PH_LOW) begin
                o_res.cnt = 2'd1;
                o_res.b0  = {i_nib, 4'd0} + dval;
            end else if (i_byte == CH_PCT) begin
                if (i_last) begin
                    o_res.cnt = 2'd1;
                    o_res.err = 1'b1;
                end else begin
                    o_res.phase = PH_HIGH;
                end
            end else if (i_byte == CH_PLUS) begin
                o_res.cnt = 2'd1;
                o_res.b0  = CH_SPACE;
            end else begin
                o_res.cnt = 2'd1;
                o_res.b0  = i_byte;
            end
        end
    end

endmodule

### hw/rtl/ucodec_outbuf.sv
`timescale 1ns / 1ps

module ucodec_outbuf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  ucodec_pkg::t_xres             i_res,
    input  logic                          i_ready,
    output logic                          o_can_load,
    output logic                          o_valid,
    output logic [ucodec_pkg::BYTE_W-1:0] o_byte,
    output logic                          o_run_end,
    output logic                          o_str_end,
    output logic                          o_err
);
    import ucodec_pkg::*;

    logic [CNT_W-1:0]  r_rem;
    logic [BYTE_W-1:0] r_b0;
    logic [BYTE_W-1:0] r_b1;
    logic [BYTE_W-1:0] r_b2;
    logic              r_last;
    logic              r_err;
    logic              take;

    assign o_valid    = (r_rem != '0);
    assign take       = o_valid && i_ready;
    assign o_can_load = (r_rem == '0) || ((r_rem == 2'd1) && take);
    assign o_byte     = r_b0;
    assign o_run_end  = (r_rem == 2'd1);
    assign o_str_end  = (r_rem == 2'd1) && r_last;
    assign o_err      = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_res.cnt;
        end else if (take) begin
            r_rem <= r_rem - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b0   <= i_res.b0;
            r_b1   <= i_res.b1;
            r_b2   <= i_res.b2;
            r_last <= i_res.last;
            r_err  <= i_res.err;
        end else if (take) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

endmodule

### hw/rtl/url_percent_codec.sv
`timescale 1ns / 1ps
// Path: a taken input byte passes the input register, then the result register, before its first result shows.
// One input byte per cycle for one-result bytes while the output is ready; an encoded escape holds
// the result register for its three result bytes, so the next byte waits in the input register.
// Reset: synchronous, active low; clears direction (encode), escape state and
// both stage valids. A direction write also clears the escape state.
module url_percent_codec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ucodec_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] in_byte
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ucodec_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] out_byte
    output logic                          m_axis_tlast,
    output logic [1:0]                    m_axis_tuser   // [0] run_end, [1] escape_error
);
    import ucodec_pkg::*;

    logic              r_dir;
    logic [PH_W-1:0]   r_phase;
    logic [NIB_W-1:0]  r_nib;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              can_load;
    logic              advance;
    logic              s_take;
    logic              run_end;
    logic              err;
    t_xres             xres;

    assign advance       = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_phase <= PH_IDLE;
            r_nib   <= '0;
        end else if (i_cfg_we) begin
            r_dir   <= i_cfg_data;
            r_phase <= PH_IDLE;
            r_nib   <= '0;
        end else if (advance) begin
            r_phase <= xres.phase;
            r_nib   <= xres.nib;
        end
    end

    ucodec_xlate u_xlate (
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_dir   (r_dir),
        .i_phase (r_phase),
        .i_nib   (r_nib),
        .o_res   (xres)
    );

    ucodec_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (xres),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_byte     (m_axis_tdata),
        .o_run_end  (run_end),
        .o_str_end  (m_axis_tlast),
        .o_err      (err)
    );

    assign m_axis_tuser = {err, run_end};

    a_encode_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir == DIR_ENCODE) |-> (r_phase == PH_IDLE))
        else $error("escape state active in encode mode");

    a_error_ends_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && m_axis_tuser[0]
            && (m_axis_tdata == '0)))
        else $error("error result not a closing zero item");

    a_string_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("string end without run end");

    a_last_clears_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(advance) && $past(r_in_last)) |-> (r_phase == PH_IDLE))
        else $error("escape state left open after last byte");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ucodec_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_end;
        logic              str_end;
        logic              esc_err;
    } res_t;

    typedef struct packed {
        logic              wr_dir;
        logic              dir;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              typed;
        logic              none;
        res_t              want;
    } row_t;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic              i_cfg_data = DIR_ENCODE;
    logic              s_tvalid   = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata    = '0;
    logic              s_tlast    = 1'b0;
    logic              m_tvalid;
    logic              m_tready   = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic [1:0]        m_tuser;

    // predictor state
    logic              cur_dir   = DIR_ENCODE;
    logic [PH_W-1:0]   esc_phase = PH_IDLE;
    logic [NIB_W-1:0]  esc_nib   = '0;
    res_t              step_out [3];

    res_t conv_q [$];
    logic calm = 1'b0;
    int   bytes_sent = 0;
    int   dir_writes = 0;
    int   results = 0;
    int   err_items = 0;
    int   fails = 0;

    // after reset, space, plus, escape prefixes and escape errors typed in; extremes and the rest predicted
    row_t dir_rows [25] = '{
        '{1'b1, DIR_ENCODE, "A",     1'b0, 1'b1, 1'b0, '{"A", 1'b1, 1'b0, 1'b0}},
        '{1'b0, DIR_ENCODE, "z",     1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, "0",     1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, "9",     1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, CH_DASH, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, CH_USCORE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, CH_DOT,  1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, CH_TILDE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, CH_SPACE, 1'b0, 1'b1, 1'b0, '{CH_PLUS, 1'b1, 1'b0, 1'b0}},
        '{1'b0, DIR_ENCODE, 8'h00,   1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_ENCODE, 8'hFF,   1'b1, 1'b0, 1'b0, '0},
        '{1'b1, DIR_DECODE, CH_PLUS, 1'b0, 1'b1, 1'b0, '{CH_SPACE, 1'b1, 1'b0, 1'b0}},
        '{1'b0, DIR_DECODE, CH_PCT,  1'b0, 1'b1, 1'b1, '0},
        '{1'b0, DIR_DECODE, "4",     1'b0, 1'b1, 1'b1, '0},
        '{1'b0, DIR_DECODE, "1",     1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_DECODE, CH_PCT,  1'b1, 1'b1, 1'b0, '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{1'b0, DIR_DECODE, CH_PCT,  1'b0, 1'b1, 1'b1, '0},
        '{1'b0, DIR_DECODE, "z",     1'b1, 1'b1, 1'b0, '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{1'b0, DIR_DECODE, CH_PCT,  1'b0, 1'b1, 1'b1, '0},
        '{1'b1, DIR_DECODE, "G",     1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_DECODE, CH_PCT,  1'b0, 1'b1, 1'b1, '0},
        '{1'b0, DIR_DECODE, "Z",     1'b0, 1'b1, 1'b1, '0},
        '{1'b0, DIR_DECODE, "z",     1'b0, 1'b0, 1'b0, '0},
        '{1'b0, DIR_DECODE, 8'hFF,   1'b1, 1'b0, 1'b0, '0},
        '{1'b0, DIR_DECODE, 8'h00,   1'b1, 1'b0, 1'b0, '0}
    };

    url_percent_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [NIB_W-1:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h41 + n - 8'd10;
    endfunction

    // returns how many bytes the codec emits for one request
    function automatic int convert_byte(input logic [BYTE_W-1:0] c, input logic l);
        logic [BYTE_W-1:0] dv;
        logic              plain;
        plain = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9")
            || c == CH_DASH || c == CH_USCORE || c == CH_DOT || c == CH_TILDE;
        if (c >= "A" && c <= "Z") begin
            dv = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "z") begin
            dv = c - "a" + 8'd10;
        end else if (c >= "0" && c <= "9") begin
            dv = c - "0";
        end else begin
            dv = 8'd0;
        end
        if (cur_dir == DIR_ENCODE) begin
            esc_phase = PH_IDLE;
            if (plain) begin
                step_out[0] = '{c, 1'b1, l, 1'b0};
                return 1;
            end
            if (c == CH_SPACE) begin
                step_out[0] = '{CH_PLUS, 1'b1, l, 1'b0};
                return 1;
            end
            step_out[0] = '{CH_PCT, 1'b0, 1'b0, 1'b0};
            step_out[1] = '{hex_digit(c[7:4]), 1'b0, 1'b0, 1'b0};
            step_out[2] = '{hex_digit(c[3:0]), 1'b1, l, 1'b0};
            return 3;
        end
        case (esc_phase)
            PH_HIGH: begin
                if (l) begin
                    esc_phase = PH_IDLE;
                    esc_nib = '0;
                    step_out[0] = '{8'h00, 1'b1, 1'b1, 1'b1};
                    return 1;
                end
                esc_nib = dv[3:0];
                esc_phase = PH_LOW;
                return 0;
            end
            PH_LOW: begin
                step_out[0] = '{{esc_nib, 4'd0} + dv, 1'b1, l, 1'b0};
                esc_phase = PH_IDLE;
                esc_nib = '0;
                return 1;
            end
            default: begin
                if (c == CH_PCT) begin
                    if (l) begin
                        step_out[0] = '{8'h00, 1'b1, 1'b1, 1'b1};
                        return 1;
                    end
                    esc_phase = PH_HIGH;
                    return 0;
                end
                step_out[0] = '{(c == CH_PLUS) ? CH_SPACE : c, 1'b1, l, 1'b0};
                return 1;
            end
        endcase
    endfunction

    // valid is left high after the request; a gap in the next call, set_dir or the end of the test lowers it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l,
                             input logic typed = 1'b0, input logic none = 1'b0,
                             input res_t want = '0);
        int g;
        int n;
        g = calm ? 0 : $urandom_range(0, 13);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge i_clk); while (!s_tready);
        n = convert_byte(b, l);
        if (typed) begin
            if (!none) conv_q.push_back(want);
        end else begin
            for (int k = 0; k < n; k++) conv_q.push_back(step_out[k]);
        end
        bytes_sent++;
    endtask

    task automatic set_dir(input logic d);
        s_tvalid <= 1'b0;
        while (conv_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_dir   = d;
        esc_phase = PH_IDLE;
        esc_nib   = '0;
        dir_writes++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_digit();
        case ($urandom_range(0, 5))
            0, 1:    return BYTE_W'(8'h30 + $urandom_range(0, 9));
            2:       return BYTE_W'(8'h41 + $urandom_range(0, 5));
            3:       return BYTE_W'(8'h61 + $urandom_range(0, 5));
            4:       return BYTE_W'(($urandom_range(0, 1) ? 8'h41 : 8'h61)
                                    + $urandom_range(0, 25));
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_string();
        logic [BYTE_W-1:0] str_q [$];
        logic [BYTE_W-1:0] c;
        int len;
        int kind;
        len  = $urandom_range(1, 10);
        kind = $urandom_range(0, 9);
        if (cur_dir == DIR_ENCODE || kind == 0) begin
            repeat (len) begin
                case ($urandom_range(0, 5))
                    0: c = BYTE_W'(8'h41 + $urandom_range(0, 25));
                    1: c = BYTE_W'(8'h61 + $urandom_range(0, 25));
                    2: c = BYTE_W'(8'h30 + $urandom_range(0, 9));
                    3: c = CH_SPACE;
                    4: begin
                        case ($urandom_range(0, 3))
                            0: c = CH_DASH;
                            1: c = CH_USCORE;
                            2: c = CH_DOT;
                            default: c = CH_TILDE;
                        endcase
                    end
                    default: c = BYTE_W'($urandom_range(0, 255));
                endcase
                str_q.push_back(c);
            end
        end else begin
            while (str_q.size() < len) begin
                case ($urandom_range(0, 3))
                    0: str_q.push_back(CH_PLUS);
                    1: begin
                        c = BYTE_W'($urandom_range(0, 255));
                        str_q.push_back((c == CH_PCT) ? CH_PLUS : c);
                    end
                    default: begin
                        str_q.push_back(CH_PCT);
                        str_q.push_back(pick_digit());
                        str_q.push_back(pick_digit());
                    end
                endcase
            end
            // string cut off inside an escape
            if (kind == 1) begin
                str_q.push_back(CH_PCT);
                if ($urandom_range(0, 1)) str_q.push_back(pick_digit());
            end
        end
        foreach (str_q[k]) send_byte(str_q[k], k == str_q.size() - 1);
    endtask

    initial begin
        res_t got;
        res_t want;
        int   st;
        wait (i_rst_n);
        forever begin
            st = calm ? 0 : $urandom_range(0, 13);
            if (st > 0) begin
                m_tready <= 1'b0;
                repeat (st) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            results++;
            if (got.esc_err) err_items++;
            if (conv_q.size() == 0) begin
                $display("%0t: unexpected result byte %h run_end %b string_end %b error %b",
                         $time, got.data, got.run_end, got.str_end, got.esc_err);
                fails++;
            end else begin
                want = conv_q.pop_front();
                if (got !== want) begin
                    $display({"%0t: mismatch expected byte %h run_end %b string_end %b ",
                              "error %b, got byte %h run_end %b string_end %b error %b"},
                             $time, want.data, want.run_end, want.str_end, want.esc_err,
                             got.data, got.run_end, got.str_end, got.esc_err);
                    fails++;
                end
            end
        end
    end

    initial begin
        int phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].wr_dir) set_dir(dir_rows[i].dir);
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].none, dir_rows[i].want);
        end

        phase = 0;
        while (bytes_sent < 340) begin
            set_dir(phase[0] ? DIR_ENCODE : DIR_DECODE);
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 8)) send_random_string();
            calm = 1'b0;
            phase++;
        end

        s_tvalid <= 1'b0;
        while (conv_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d input bytes under %0d direction writes, both directions.",
                 bytes_sent, dir_writes);
        $display("Checked %0d results, %0d unfinished-escape errors, %0d mismatches.",
                 results, err_items, fails);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
